// ===== design/pgpb_pkg.sv =====
// page permission bitmap: shared package
// holds opcodes, entry layout and the controller/datapath command and status structs
// no dependencies
`default_nettype none

package pgpb_pkg;

	localparam int ENTRY_W = 4;
	localparam int OPCODE_W = 2;
	localparam int PROT_W = 3;
	localparam int SEL_W = 2;
	localparam int START_W = 24;
	localparam int LENGTH_W = 25;

	localparam logic [OPCODE_W-1:0] OP_SET = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_GRANT = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_REVOKE = 2'd3;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_RANGE_ERR = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic rd;
		logic walk;
		logic out_load;
	} pgpb_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_last;
		logic walk_last;
		logic is_query;
		logic skip;
	} pgpb_stat_t;

endpackage

`default_nettype wire

// ===== design/pgpb_ctrl.sv =====
// page permission bitmap: controller state machine
// sequences the clearing pass, range walk, query and result handoff
// depends on pgpb_pkg
`default_nettype none

module pgpb_ctrl import pgpb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire pgpb_stat_t stat,
	output pgpb_cmd_t       cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_WALK   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.is_query) begin
					cmd.rd = 1'b1;
					state_d = ST_FINISH;
				end else if (stat.skip) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.rd = 1'b1;
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/pgpb_dp.sv =====
// page permission bitmap: datapath
// request registers, range check, page counter, permission table and result registers
// depends on pgpb_pkg
`default_nettype none

module pgpb_dp import pgpb_pkg::*; #(
	parameter int ADDR_BITS = 24,
	parameter int PAGE_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pgpb_cmd_t           cmd,
	output pgpb_stat_t               stat,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [START_W-1:0]  start_address,
	input  wire logic [LENGTH_W-1:0] length,
	input  wire logic [PROT_W-1:0]   prot_in,
	input  wire logic [SEL_W-1:0]    map_select,
	output logic [PROT_W-1:0]        prot_out,
	output logic                     status
);

	localparam int PW = ADDR_BITS - PAGE_BITS;
	localparam longint NUM_PAGES = 64'sd1 <<< PW;
	// wide enough for start + length and for the address space size
	localparam int SW = ((ADDR_BITS > LENGTH_W) ? ADDR_BITS : LENGTH_W) + 1;
	localparam logic [SW-1:0] SPACE = SW'(1) << ADDR_BITS;
	localparam logic [SW-1:0] ADDR_MASK = SPACE - SW'(1);

	logic [OPCODE_W-1:0] op_q;
	logic [PROT_W-1:0]   prot_q;
	logic [ENTRY_W-1:0]  sel_q;
	logic                len_zero_q;
	logic [SW-1:0]       sum_q;
	logic [PW-1:0]       cur_q;
	logic [PW-1:0]       pg_s1;
	logic                wr_v_s1;
	logic [ENTRY_W-1:0]  rd_q;
	logic [PROT_W-1:0]   prot_out_q;
	logic                status_q;
	logic [ENTRY_W-1:0]  mem_q [0:NUM_PAGES-1];

	logic [SW-1:0]      addr_ext;
	logic [SW-1:0]      sum_m1;
	logic [PW-1:0]      last_pg;
	logic               range_err;
	logic [ENTRY_W-1:0] new_entry;

	// wrapped address and range bounds
	assign addr_ext = SW'(start_address) & ADDR_MASK;
	assign sum_m1 = sum_q - SW'(1);
	assign last_pg = sum_m1[ADDR_BITS-1:PAGE_BITS];
	assign range_err = sum_q > SPACE;

	assign stat.clear_last = &cur_q;
	assign stat.walk_last = cur_q == last_pg;
	assign stat.is_query = op_q == OP_QUERY;
	assign stat.skip = range_err || len_zero_q;

	// capture request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			prot_q <= prot_in;
			sel_q <= ENTRY_W'(1) << map_select;
			len_zero_q <= length == '0;
			sum_q <= addr_ext + SW'(length);
		end
	end

	// page counter, shared by clearing pass and walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			wr_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= cmd.walk;
			if (cmd.load) begin
				cur_q <= addr_ext[ADDR_BITS-1:PAGE_BITS];
			end else if (cmd.clear_step || cmd.walk) begin
				cur_q <= cur_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		pg_s1 <= cur_q;
	end

	// entry update for the page read in the previous cycle
	always_comb begin
		case (op_q)
			OP_SET:    new_entry = {rd_q[ENTRY_W-1], prot_q};
			OP_GRANT:  new_entry = rd_q | sel_q;
			OP_REVOKE: new_entry = rd_q & ~sel_q;
			default:   new_entry = rd_q;
		endcase
	end

	// permission table, one write and one read port
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem_q[cur_q] <= '0;
		end else if (wr_v_s1) begin
			mem_q[pg_s1] <= new_entry;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[cur_q];
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (op_q == OP_QUERY) begin
				prot_out_q <= rd_q[PROT_W-1:0];
				status_q <= STATUS_DONE;
			end else begin
				prot_out_q <= '0;
				status_q <= range_err ? STATUS_RANGE_ERR : STATUS_DONE;
			end
		end
	end

	assign prot_out = prot_out_q;
	assign status = status_q;

endmodule

`default_nettype wire

// ===== design/page_permission_bitmap.sv =====
// page permission bitmap: top level
// joins the controller (pgpb_ctrl) and the datapath (pgpb_dp); depends on pgpb_pkg
//
// Keeps a 4-bit entry (read, write, execute, dirty) for each page of a flat
// page table of 2^(ADDR_BITS-PAGE_BITS) pages. One request on the input
// channel (in_valid/in_ready) gives exactly one result on the output channel
// (out_valid/out_ready): prot_out for a query, status 1 for a range that runs
// past the end of the address space (nothing changes then).
// After acceptance a query reads its entry, a refused range or a zero length
// changes nothing, and a range covering n pages is walked page by page; the
// page walk does one read-modify-write of the table per cycle, pipelined over
// its single read port and single write port. A new request can be taken in
// the cycle after the previous result is loaded into the output register.
// After reset every page of the table is swept to zero, one page per cycle;
// in_ready stays low meanwhile. If the receiver stalls, the result waits in
// the output register; the next request is still accepted and worked, and its
// result is held until the output register frees up.
`default_nettype none

module page_permission_bitmap import pgpb_pkg::*; #(
	parameter int ADDR_BITS = 24,
	parameter int PAGE_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [START_W-1:0]  start_address,
	input  wire logic [LENGTH_W-1:0] length,
	input  wire logic [PROT_W-1:0]   prot_in,
	input  wire logic [SEL_W-1:0]    map_select,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [PROT_W-1:0]        prot_out,
	output logic                     status
);

	pgpb_cmd_t  cmd;
	pgpb_stat_t stat;

	// sequencing
	pgpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table and arithmetic
	pgpb_dp #(
		.ADDR_BITS (ADDR_BITS),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (opcode),
		.start_address (start_address),
		.length        (length),
		.prot_in       (prot_in),
		.map_select    (map_select),
		.prot_out      (prot_out),
		.status        (status)
	);

endmodule

`default_nettype wire
